// File: hw/rtl/bba_pkg.sv
// Package for the block bitmap allocator: sizes, codes, transaction structs
// and the word-level helper functions used by the sequencer.
// No dependencies.
package bba_pkg;

  localparam int MAX_BLOCKS  = 1024;
  localparam int MAX_REQUEST = 64;
  localparam int WORD_W      = 32;
  localparam int NUM_WORDS   = MAX_BLOCKS / WORD_W;
  localparam int NUM_BYTES   = WORD_W / 8;
  localparam int WORD_IDX_W  = $clog2(NUM_WORDS);
  localparam int BIT_IDX_W   = $clog2(WORD_W);
  localparam int BYTE_IDX_W  = $clog2(NUM_BYTES);
  localparam int POP_W       = $clog2(WORD_W) + 1;

  localparam int BLOCK_W  = 10;
  localparam int TOTAL_W  = 11;
  localparam int COUNT_W  = 7;
  localparam int OPCODE_W = 3;
  localparam int STATUS_W = 3;
  localparam int CFG_IDX_W = 1;

  typedef enum logic [OPCODE_W-1:0] {
    OP_ALLOC_ONE  = 3'd0,
    OP_ALLOC_MANY = 3'd1,
    OP_FREE       = 3'd2,
    OP_TEST       = 3'd3,
    OP_CLEAR      = 3'd4
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK           = 3'd0,
    STAT_NO_SPACE     = 3'd1,
    STAT_OUT_OF_RANGE = 3'd2,
    STAT_RESERVED     = 3'd3,
    STAT_ALREADY_FREE = 3'd4,
    STAT_ZERO_COUNT   = 3'd5
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TOTAL_BLOCKS = 1'b0,
    REG_FIRST_DATA   = 1'b1
  } reg_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RC_RD,
    S_RC_ACC,
    S_DISPATCH,
    S_SCAN_RD,
    S_SCAN_LOAD,
    S_SCAN_CHECK,
    S_BIT_CHECK
  } state_e;

  typedef struct packed {
    logic [OPCODE_W-1:0] opcode;
    logic [BLOCK_W-1:0]  block_id;
    logic [COUNT_W-1:0]  count;
  } bba_req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [BLOCK_W-1:0]  granted_block;
    logic                is_free;
    logic [TOTAL_W-1:0]  free_count;
    logic                last;
  } bba_res_t;

  function automatic logic [POP_W-1:0] word_popcount(input logic [WORD_W-1:0] v);
    logic [POP_W-1:0] sum;
    logic [3:0]       part;
    sum = '0;
    for (int by = 0; by < NUM_BYTES; by++) begin
      part = '0;
      for (int i = 0; i < 8; i++) begin
        part = part + 4'(v[by*8+i]);
      end
      sum = sum + POP_W'(part);
    end
    return sum;
  endfunction

  function automatic logic [BIT_IDX_W-1:0] lowest_one(input logic [WORD_W-1:0] v);
    logic [7:0]            sel;
    logic [BYTE_IDX_W-1:0] byte_n;
    logic [2:0]            bit_n;
    sel    = v[7:0];
    byte_n = '0;
    bit_n  = '0;
    for (int by = NUM_BYTES - 1; by >= 0; by--) begin
      if (v[by*8 +: 8] != 8'd0) begin
        sel    = v[by*8 +: 8];
        byte_n = BYTE_IDX_W'(by);
      end
    end
    for (int i = 7; i >= 0; i--) begin
      if (sel[i]) begin
        bit_n = 3'(i);
      end
    end
    return {byte_n, bit_n};
  endfunction

  // Bits of word w that lie inside the data range [fdb, top).
  function automatic logic [WORD_W-1:0] word_mask(input logic [WORD_IDX_W-1:0] w,
                                                  input logic [BLOCK_W-1:0]    fdb,
                                                  input logic [TOTAL_W-1:0]    top);
    logic [TOTAL_W-1:0] base;
    logic [TOTAL_W-1:0] fdb_x;
    logic [TOTAL_W-1:0] gap;
    logic [WORD_W-1:0]  lo_m;
    logic [WORD_W-1:0]  hi_m;
    base  = TOTAL_W'({w, BIT_IDX_W'(0)});
    fdb_x = TOTAL_W'(fdb);
    gap   = '0;
    if (fdb_x <= base) begin
      lo_m = '1;
    end else begin
      gap = fdb_x - base;
      if (gap >= TOTAL_W'(WORD_W)) begin
        lo_m = '0;
      end else begin
        lo_m = {WORD_W{1'b1}} << gap[BIT_IDX_W-1:0];
      end
    end
    if (top <= base) begin
      hi_m = '0;
    end else begin
      gap = top - base;
      if (gap >= TOTAL_W'(WORD_W)) begin
        hi_m = '1;
      end else begin
        hi_m = ~({WORD_W{1'b1}} << gap[BIT_IDX_W-1:0]);
      end
    end
    return lo_m & hi_m;
  endfunction

endpackage

// File: hw/rtl/bba_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/block_bitmap_allocator.sv
// First-fit block bitmap allocator: a word-wide bitmap RAM swept by a small sequencer.
// Depends on bba_pkg and bba_ram.
// Clear and rejections answer at dispatch; free and test of a data block first read the
// bitmap word. Allocation sweeps the bitmap word by word (read, load, check) up to the
// first grant, then one further grant per cycle while the same word has free blocks.
// One transaction at a time: busy falls as its last result appears. After reset and after
// any configuration write, the next command first recounts free blocks.
// Reset leaves the map empty. Results cannot be stalled.
module block_bitmap_allocator (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  bba_pkg::bba_req_t               req_i,
  output logic                            res_strobe_o,
  output bba_pkg::bba_res_t               res_o,
  input  logic                            cfg_we_i,
  input  logic [bba_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [bba_pkg::TOTAL_W-1:0]     cfg_wdata_i
);
  import bba_pkg::*;

  state_e                state_q, state_d;
  bba_req_t              req_q, req_d;
  logic [COUNT_W-1:0]    left_q, left_d;
  logic [WORD_IDX_W-1:0] wptr_q, wptr_d;
  logic [TOTAL_W-1:0]    acc_q, acc_d;
  logic [TOTAL_W-1:0]    free_q, free_d;
  logic                  recount_q, recount_d;
  logic [TOTAL_W-1:0]    total_q;
  logic [BLOCK_W-1:0]    fdb_q;
  logic [NUM_WORDS-1:0]  row_valid_q, row_valid_d;
  logic                  rvalid_q;
  logic [WORD_W-1:0]     cur_q, cur_d;
  bba_res_t              res_q, res_d;
  logic                  strobe_q, strobe_d;

  logic                  ram_we;
  logic [WORD_IDX_W-1:0] ram_waddr;
  logic [WORD_W-1:0]     ram_wdata;
  logic [WORD_IDX_W-1:0] ram_raddr;
  logic [WORD_W-1:0]     ram_rdata;

  logic [WORD_W-1:0]     rd_word;
  logic [TOTAL_W-1:0]    top_blocks;
  logic [WORD_IDX_W-1:0] id_word;
  logic [BIT_IDX_W-1:0]  id_bit;
  logic [WORD_W-1:0]     avail;
  logic [BIT_IDX_W-1:0]  grant_bit;
  logic                  id_out_of_range;
  logic                  id_reserved;

  bba_ram #(
    .WIDTH(WORD_W),
    .DEPTH(NUM_WORDS)
  ) u_map_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign rd_word    = rvalid_q ? ram_rdata : '0;
  assign top_blocks = (total_q > TOTAL_W'(MAX_BLOCKS)) ? TOTAL_W'(MAX_BLOCKS) : total_q;
  assign id_word    = req_q.block_id[BLOCK_W-1 -: WORD_IDX_W];
  assign id_bit     = req_q.block_id[BIT_IDX_W-1:0];
  assign avail      = ~cur_q & word_mask(wptr_q, fdb_q, top_blocks);
  assign grant_bit  = lowest_one(avail);
  assign id_out_of_range = TOTAL_W'(req_q.block_id) >= top_blocks;
  assign id_reserved     = req_q.block_id < fdb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      free_q      <= '0;
      recount_q   <= 1'b1;
      total_q     <= TOTAL_W'(MAX_BLOCKS);
      fdb_q       <= BLOCK_W'(1);
      row_valid_q <= '0;
      rvalid_q    <= 1'b0;
      strobe_q    <= 1'b0;
    end else begin
      state_q     <= state_d;
      free_q      <= free_d;
      recount_q   <= recount_d;
      row_valid_q <= row_valid_d;
      rvalid_q    <= row_valid_d[ram_raddr];
      strobe_q    <= strobe_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_TOTAL_BLOCKS: total_q <= cfg_wdata_i;
          REG_FIRST_DATA:   fdb_q   <= cfg_wdata_i[BLOCK_W-1:0];
          default:          ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    req_q  <= req_d;
    left_q <= left_d;
    wptr_q <= wptr_d;
    acc_q  <= acc_d;
    cur_q  <= cur_d;
    res_q  <= res_d;
  end

  always_comb begin
    state_d     = state_q;
    req_d       = req_q;
    left_d      = left_q;
    wptr_d      = wptr_q;
    acc_d       = acc_q;
    free_d      = free_q;
    recount_d   = recount_q;
    row_valid_d = row_valid_q;
    cur_d       = cur_q;
    res_d       = res_q;
    strobe_d    = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = wptr_q;
    ram_wdata   = cur_q;
    ram_raddr   = wptr_q;

    case (state_q)
      S_IDLE: begin
        if (start && (req_i.opcode <= OP_CLEAR)) begin
          req_d   = req_i;
          wptr_d  = '0;
          acc_d   = '0;
          state_d = recount_q ? S_RC_RD : S_DISPATCH;
        end
      end
      S_RC_RD: begin
        state_d = S_RC_ACC;
      end
      S_RC_ACC: begin
        acc_d = acc_q + TOTAL_W'(word_popcount(~rd_word & word_mask(wptr_q, fdb_q,
                                                                     top_blocks)));
        if (wptr_q == WORD_IDX_W'(NUM_WORDS - 1)) begin
          free_d    = acc_d;
          recount_d = 1'b0;
          state_d   = S_DISPATCH;
        end else begin
          wptr_d  = wptr_q + WORD_IDX_W'(1);
          state_d = S_RC_RD;
        end
      end
      S_DISPATCH: begin
        res_d   = '0;
        wptr_d  = '0;
        state_d = S_IDLE;
        case (req_q.opcode)
          OP_ALLOC_ONE: begin
            if (free_q == '0) begin
              res_d.status = STAT_NO_SPACE;
              strobe_d     = 1'b1;
            end else begin
              left_d  = COUNT_W'(1);
              state_d = S_SCAN_RD;
            end
          end
          OP_ALLOC_MANY: begin
            if (req_q.count == '0) begin
              res_d.status = STAT_ZERO_COUNT;
              strobe_d     = 1'b1;
            end else if (req_q.count > COUNT_W'(MAX_REQUEST)) begin
              res_d.status = STAT_OUT_OF_RANGE;
              strobe_d     = 1'b1;
            end else if (free_q < TOTAL_W'(req_q.count)) begin
              res_d.status = STAT_NO_SPACE;
              strobe_d     = 1'b1;
            end else begin
              left_d  = req_q.count;
              state_d = S_SCAN_RD;
            end
          end
          OP_FREE: begin
            if (id_out_of_range) begin
              res_d.status = STAT_OUT_OF_RANGE;
              strobe_d     = 1'b1;
            end else if (id_reserved) begin
              res_d.status = STAT_RESERVED;
              strobe_d     = 1'b1;
            end else begin
              ram_raddr = id_word;
              state_d   = S_BIT_CHECK;
            end
          end
          OP_TEST: begin
            if (id_out_of_range || id_reserved) begin
              res_d.status = STAT_OK;
              strobe_d     = 1'b1;
            end else begin
              ram_raddr = id_word;
              state_d   = S_BIT_CHECK;
            end
          end
          OP_CLEAR: begin
            row_valid_d  = '0;
            free_d       = (top_blocks > TOTAL_W'(fdb_q)) ? top_blocks - TOTAL_W'(fdb_q) : '0;
            res_d.status = STAT_OK;
            strobe_d     = 1'b1;
          end
          default: ;
        endcase
      end
      S_SCAN_RD: begin
        state_d = S_SCAN_LOAD;
      end
      S_SCAN_LOAD: begin
        cur_d   = rd_word;
        state_d = S_SCAN_CHECK;
      end
      S_SCAN_CHECK: begin
        if (avail == '0) begin
          wptr_d  = wptr_q + WORD_IDX_W'(1);
          state_d = S_SCAN_RD;
        end else begin
          cur_d                = cur_q | (WORD_W'(1) << grant_bit);
          ram_we               = 1'b1;
          ram_wdata            = cur_d;
          row_valid_d[wptr_q]  = 1'b1;
          free_d               = free_q - TOTAL_W'(1);
          left_d               = left_q - COUNT_W'(1);
          res_d                = '0;
          res_d.status         = STAT_OK;
          res_d.granted_block  = {wptr_q, grant_bit};
          strobe_d             = 1'b1;
          if (left_q == COUNT_W'(1)) begin
            state_d = S_IDLE;
          end
        end
      end
      S_BIT_CHECK: begin
        res_d    = '0;
        strobe_d = 1'b1;
        state_d  = S_IDLE;
        if (req_q.opcode == OP_FREE) begin
          if (!rd_word[id_bit]) begin
            res_d.status = STAT_ALREADY_FREE;
          end else begin
            ram_we               = 1'b1;
            ram_waddr            = id_word;
            ram_wdata            = rd_word & ~(WORD_W'(1) << id_bit);
            row_valid_d[id_word] = 1'b1;
            free_d               = free_q + TOTAL_W'(1);
            res_d.status         = STAT_OK;
          end
        end else begin
          res_d.status  = STAT_OK;
          res_d.is_free = !rd_word[id_bit];
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (cfg_we_i) begin
      recount_d = 1'b1;
    end

    if (strobe_d) begin
      res_d.free_count = free_d;
      res_d.last       = (state_d == S_IDLE);
    end
  end

  assign busy         = (state_q != S_IDLE);
  assign res_strobe_o = strobe_q;
  assign res_o        = res_q;

`ifndef ASSERT_OFF
  a_free_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    free_q <= TOTAL_W'(MAX_BLOCKS))
    else $error("free count exceeds the volume size");

  a_grant_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_strobe_o && res_o.status == STAT_OK &&
     (req_q.opcode == OP_ALLOC_ONE || req_q.opcode == OP_ALLOC_MANY))
    |-> (res_o.granted_block >= fdb_q && TOTAL_W'(res_o.granted_block) < top_blocks))
    else $error("granted block lies outside the data range");

  a_start_takes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && req_i.opcode <= OP_CLEAR) |=> busy)
    else $error("accepted transaction did not start the sequencer");

  a_counted_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_strobe_o |-> !recount_q)
    else $error("result issued while the free count was stale");
`endif

endmodule

// File: test/block_bitmap_allocator_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for block_bitmap_allocator: directed and random command streams
// under several volume settings, checked against a bitmap predictor held in the bench.
// Depends on bba_pkg and the allocator RTL.
module block_bitmap_allocator_test;
  import bba_pkg::*;

  localparam int IDLE_LIMIT    = 3000;
  localparam int SETTLE_CYCLES = 250;
  localparam int EXP_DEPTH     = 1024;
  localparam logic [OPCODE_W-1:0] OP_UNUSED_LO = 3'd5;
  localparam logic [OPCODE_W-1:0] OP_UNUSED_HI = 3'd7;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 start       = 1'b0;
  logic                 busy;
  bba_req_t             req_i       = '0;
  logic                 res_strobe_o;
  bba_res_t             res_o;
  logic                 cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i   = '0;
  logic [TOTAL_W-1:0]   cfg_wdata_i = '0;

  logic [MAX_BLOCKS-1:0] block_used;
  logic [TOTAL_W-1:0]    vol_total;
  logic [BLOCK_W-1:0]    vol_first_data;
  bba_res_t              expected_mem[EXP_DEPTH];
  int                    exp_wr = 0;
  int                    exp_rd = 0;
  int                    errors = 0;
  int                    quiet_cycles = 0;
  bit                    bursts_on = 1'b0;

  block_bitmap_allocator u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .req_i        (req_i),
    .res_strobe_o (res_strobe_o),
    .res_o        (res_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic int pending_results();
    return exp_wr - exp_rd;
  endfunction

  task automatic add_expected(bba_res_t r);
    expected_mem[exp_wr % EXP_DEPTH] = r;
    exp_wr++;
  endtask

  function automatic int data_top();
    return (vol_total < MAX_BLOCKS) ? int'(vol_total) : MAX_BLOCKS;
  endfunction

  function automatic int free_data_blocks();
    int n;
    n = 0;
    for (int i = int'(vol_first_data); i < data_top(); i++) begin
      if (!block_used[i]) n++;
    end
    return n;
  endfunction

  function automatic int lowest_free_block(int from);
    for (int i = from; i < data_top(); i++) begin
      if (!block_used[i]) return i;
    end
    return -1;
  endfunction

  task automatic predict_command(bba_req_t r);
    bba_res_t res;
    int       b;
    int       nfree;
    int       top;
    top  = data_top();
    res  = '0;
    res.last = 1'b1;
    case (r.opcode)
      OP_ALLOC_ONE: begin
        b = lowest_free_block(int'(vol_first_data));
        if (b < 0) begin
          res.status = STAT_NO_SPACE;
        end else begin
          block_used[b]     = 1'b1;
          res.granted_block = BLOCK_W'(b);
        end
        res.free_count = TOTAL_W'(free_data_blocks());
        add_expected(res);
      end
      OP_ALLOC_MANY: begin
        nfree = free_data_blocks();
        if (r.count == 0) begin
          res.status = STAT_ZERO_COUNT;
        end else if (r.count > MAX_REQUEST) begin
          res.status = STAT_OUT_OF_RANGE;
        end else if (nfree < r.count) begin
          res.status = STAT_NO_SPACE;
        end
        if (res.status != STAT_OK || r.count == 0) begin
          res.free_count = TOTAL_W'(nfree);
          add_expected(res);
        end else begin
          b = int'(vol_first_data);
          for (int k = 0; k < int'(r.count); k++) begin
            b = lowest_free_block(b);
            block_used[b] = 1'b1;
            nfree--;
            res.granted_block = BLOCK_W'(b);
            res.free_count    = TOTAL_W'(nfree);
            res.last          = (k == int'(r.count) - 1);
            add_expected(res);
          end
        end
      end
      OP_FREE: begin
        if (r.block_id >= top) begin
          res.status = STAT_OUT_OF_RANGE;
        end else if (r.block_id < vol_first_data) begin
          res.status = STAT_RESERVED;
        end else if (!block_used[r.block_id]) begin
          res.status = STAT_ALREADY_FREE;
        end else begin
          block_used[r.block_id] = 1'b0;
        end
        res.free_count = TOTAL_W'(free_data_blocks());
        add_expected(res);
      end
      OP_TEST: begin
        res.is_free = (r.block_id < top) && (r.block_id >= vol_first_data) &&
                      !block_used[r.block_id];
        res.free_count = TOTAL_W'(free_data_blocks());
        add_expected(res);
      end
      OP_CLEAR: begin
        block_used     = '0;
        res.free_count = TOTAL_W'(free_data_blocks());
        add_expected(res);
      end
      default: begin
      end
    endcase
  endtask

  task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
    $display("%0t ns: %s mismatch, got %0d expected %0d", $time, what, got, want);
    errors++;
  endtask

  task automatic check_result(bba_res_t got);
    bba_res_t want;
    if (pending_results() == 0) begin
      report_mismatch("unexpected transaction, status", 16'(got.status), 16'd0);
      return;
    end
    want = expected_mem[exp_rd % EXP_DEPTH];
    exp_rd++;
    if (got.status !== want.status)
      report_mismatch("status", 16'(got.status), 16'(want.status));
    if (got.granted_block !== want.granted_block)
      report_mismatch("granted_block", 16'(got.granted_block), 16'(want.granted_block));
    if (got.is_free !== want.is_free)
      report_mismatch("is_free", 16'(got.is_free), 16'(want.is_free));
    if (got.free_count !== want.free_count)
      report_mismatch("free_count", 16'(got.free_count), 16'(want.free_count));
    if (got.last !== want.last)
      report_mismatch("last", 16'(got.last), 16'(want.last));
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (res_strobe_o) check_result(res_o);
      if ((start && !busy) || res_strobe_o) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("%0t ns: no transaction for %0d cycles", $time, IDLE_LIMIT);
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  task automatic send_command(logic [OPCODE_W-1:0] op, int id, int cnt);
    bba_req_t r;
    r.opcode   = op;
    r.block_id = BLOCK_W'(id);
    r.count    = COUNT_W'(cnt);
    start <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (busy);
    predict_command(r);
  endtask

  task automatic pause_sender(int cycles);
    start <= 1'b0;
    repeat (cycles) begin
      req_i <= bba_req_t'($urandom);
      @(posedge clk_i);
    end
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending_results() != 0) @(posedge clk_i);
  endtask

  task automatic write_register(reg_e idx, int value);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= TOTAL_W'(value);
    @(posedge clk_i);
    if (idx == REG_TOTAL_BLOCKS) begin
      vol_total = TOTAL_W'(value);
    end else begin
      vol_first_data = BLOCK_W'(value);
    end
  endtask

  // Registers change only once the allocator has finished all outstanding work.
  task automatic set_volume(int total, int first_data);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    write_register(REG_TOTAL_BLOCKS, total);
    write_register(REG_FIRST_DATA, first_data);
    cfg_we_i <= 1'b0;
  endtask

  function automatic int pick_used_block(int fallback);
    int i;
    if (data_top() <= int'(vol_first_data)) return fallback;
    repeat (16) begin
      i = $urandom_range(int'(vol_first_data), data_top() - 1);
      if (block_used[i]) return i;
    end
    return fallback;
  endfunction

  task automatic random_command(output bit counted);
    int                  pick;
    int                  id;
    int                  cnt;
    logic [OPCODE_W-1:0] op;
    pick = $urandom_range(0, 99);
    id   = $urandom_range(0, MAX_BLOCKS - 1);
    cnt  = $urandom_range(1, 6);
    if (pick < 28) begin
      op = OP_ALLOC_ONE;
    end else if (pick < 52) begin
      op = OP_ALLOC_MANY;
      case ($urandom_range(0, 9))
        0:       cnt = 0;
        1:       cnt = $urandom_range(MAX_REQUEST + 1, 127);
        2, 3:    cnt = $urandom_range(1, MAX_REQUEST);
        default: ;
      endcase
    end else if (pick < 78) begin
      op = OP_FREE;
      if ($urandom_range(0, 3) != 0) id = pick_used_block(id);
    end else if (pick < 94) begin
      op = OP_TEST;
      if ($urandom_range(0, 1) && data_top() > int'(vol_first_data))
        id = $urandom_range(int'(vol_first_data), data_top() - 1);
    end else if (pick < 97) begin
      op = OP_CLEAR;
    end else begin
      op = OPCODE_W'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
    end
    send_command(op, id, cnt);
    counted = (op <= OP_CLEAR);
  endtask

  task automatic test_reset_volume();
    send_command(OP_TEST, 0, 0);
    send_command(OP_TEST, MAX_BLOCKS - 1, 0);
    send_command(OP_TEST, 1, 0);
    send_command(OP_FREE, 0, 0);
    send_command(OP_FREE, MAX_BLOCKS - 1, 0);
    send_command(OP_ALLOC_ONE, 0, 0);
    send_command(OP_ALLOC_MANY, 0, 0);
    send_command(OP_ALLOC_MANY, 0, MAX_REQUEST);
    send_command(OP_ALLOC_MANY, 0, MAX_REQUEST + 1);
    send_command(OP_ALLOC_MANY, MAX_BLOCKS - 1, 127);
    send_command(OP_FREE, 5, 0);
    send_command(OP_ALLOC_ONE, 0, 0);
    send_command(OP_TEST, 5, 0);
    for (int op = OP_UNUSED_LO; op <= OP_UNUSED_HI; op++) begin
      send_command(OPCODE_W'(op), MAX_BLOCKS - 1, 127);
    end
    send_command(OP_CLEAR, 0, 0);
    send_command(OP_ALLOC_MANY, 0, 3);
  endtask

  task automatic test_small_volume();
    set_volume(8, 2);
    send_command(OP_ALLOC_MANY, 0, 6);
    send_command(OP_ALLOC_MANY, 0, 4);
    send_command(OP_ALLOC_ONE, 0, 0);
    send_command(OP_FREE, 9, 0);
    send_command(OP_FREE, 1, 0);
    send_command(OP_FREE, MAX_BLOCKS - 1, 0);
  endtask

  task automatic test_empty_data_range();
    set_volume(16, 20);
    send_command(OP_ALLOC_ONE, 0, 0);
    send_command(OP_ALLOC_MANY, 0, 1);
    send_command(OP_TEST, 20, 0);
  endtask

  task automatic test_random_phase(int total, int first_data, int items, bit idling);
    int sent;
    bit counted;
    set_volume(total, first_data);
    sent      = 0;
    bursts_on = idling;
    while (sent < items) begin
      random_command(counted);
      if (counted) sent++;
      if (idling && sent % 25 == 0) bursts_on = ($urandom_range(0, 2) != 0);
      if (bursts_on && $urandom_range(0, 3) == 0) begin
        pause_sender($urandom_range(1, 15));
      end else if (idling && $urandom_range(0, 59) == 0) begin
        wait_drained();
      end
    end
  endtask

  initial begin
    int total;
    block_used     = '0;
    vol_total      = TOTAL_W'(MAX_BLOCKS);
    vol_first_data = BLOCK_W'(1);
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_volume();
    test_small_volume();
    test_empty_data_range();
    test_random_phase(MAX_BLOCKS, 1, 70, 1'b1);
    test_random_phase(64, 1, 70, 1'b1);
    test_random_phase(40, 20, 60, 1'b1);
    test_random_phase(2, 1, 40, 1'b1);
    test_random_phase(MAX_BLOCKS, MAX_BLOCKS - 1, 40, 1'b1);
    test_random_phase(16, 20, 30, 1'b1);
    total = $urandom_range(2, MAX_BLOCKS);
    test_random_phase(total, $urandom_range(1, total - 1), 70, 1'b1);
    test_random_phase(300, 100, 70, 1'b0);

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
